// ===== hw/rtl/ilff_pkg.sv =====
// shared types and constants for the implicit list first-fit allocator
// no dependencies

package ilff_pkg;

    localparam int LEN_W   = 12;
    localparam int OFF_W   = 12;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [9:0] {
        S_INIT  = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_RD    = 10'b00_0000_0100,
        S_EVAL  = 10'b00_0000_1000,
        S_SPLIT = 10'b00_0001_0000,
        S_MARK  = 10'b00_0010_0000,
        S_NRD   = 10'b00_0100_0000,
        S_NEVAL = 10'b00_1000_0000,
        S_FWR   = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_INIT,
        WR_SPLIT,
        WR_MARK,
        WR_FREE,
        WR_MERGE
    } t_wr_kind;

    typedef enum logic {
        RD_POS,
        RD_NEXT
    } t_rd_sel;

    typedef struct packed {
        logic     load_req;
        logic     rd;
        t_rd_sel  rd_sel;
        logic     latch;
        logic     advance;
        t_wr_kind wr;
        logic     out_load;
        logic     out_ok;
    } t_cmd;

    typedef struct packed {
        logic is_free_op;
        logic rd_free;
        logic fits;
        logic split_ok;
        logic next_end;
        logic match;
        logic past;
    } t_stat;

endpackage

// ===== hw/rtl/ilff_ram.sv =====
// generic single-port ram with registered read
// no dependencies

module ilff_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ilff_ctrl.sv =====
// controller state machine of the allocator: walk sequencing and output handshake
// depends on ilff_pkg

module ilff_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_m_tready,
    input  ilff_pkg::t_stat i_stat,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    output ilff_pkg::t_cmd  o_cmd
);

    import ilff_pkg::*;

    t_state r_state, n_state;
    logic   r_ok, n_ok;
    logic   r_m_valid, n_m_valid;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        n_ok    = r_ok;
        w_cmd   = '{load_req: 1'b0, rd: 1'b0, rd_sel: RD_POS, latch: 1'b0,
                    advance: 1'b0, wr: WR_NONE, out_load: 1'b0, out_ok: 1'b0};
        unique case (r_state)
            S_INIT: begin
                w_cmd.wr = WR_INIT;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    w_cmd.load_req = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_RD: begin
                w_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                w_cmd.latch = 1'b1;
                if (!i_stat.is_free_op) begin
                    if (i_stat.fits) begin
                        n_ok    = 1'b1;
                        n_state = i_stat.split_ok ? S_SPLIT : S_MARK;
                    end else if (i_stat.next_end) begin
                        n_ok    = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        w_cmd.advance = 1'b1;
                        n_state       = S_RD;
                    end
                end else begin
                    if (i_stat.match) begin
                        if (i_stat.rd_free) begin
                            n_ok    = 1'b0;
                            n_state = S_DONE;
                        end else begin
                            n_ok    = 1'b1;
                            n_state = i_stat.next_end ? S_FWR : S_NRD;
                        end
                    end else if (i_stat.past || i_stat.next_end) begin
                        n_ok    = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        w_cmd.advance = 1'b1;
                        n_state       = S_RD;
                    end
                end
            end
            S_SPLIT: begin
                w_cmd.wr = WR_SPLIT;
                n_state  = S_MARK;
            end
            S_MARK: begin
                w_cmd.wr = WR_MARK;
                n_state  = S_DONE;
            end
            S_NRD: begin
                w_cmd.rd     = 1'b1;
                w_cmd.rd_sel = RD_NEXT;
                n_state      = S_NEVAL;
            end
            S_NEVAL: begin
                w_cmd.wr = i_stat.rd_free ? WR_MERGE : WR_FREE;
                n_state  = S_DONE;
            end
            S_FWR: begin
                w_cmd.wr = WR_FREE;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    w_cmd.out_load = 1'b1;
                    w_cmd.out_ok   = r_ok;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (w_cmd.out_load) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_ok      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ok      <= n_ok;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_cmd      = w_cmd;

endmodule

// ===== hw/rtl/ilff_dp.sv =====
// datapath of the allocator: request registers, walk position, header ram, result register
// depends on ilff_pkg and ilff_ram

module ilff_dp #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 16
) (
    input  logic                           i_clk,
    input  logic [ilff_pkg::S_DATA_W-1:0]  i_s_tdata,
    input  ilff_pkg::t_cmd                 i_cmd,
    output ilff_pkg::t_stat                o_stat,
    output logic [ilff_pkg::M_DATA_W-1:0]  o_m_tdata
);

    import ilff_pkg::*;

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int CW = (AW + 2 > LEN_W + 1) ? AW + 2 : LEN_W + 1;
    localparam int EW = AW + 1;

    logic             r_op;
    logic [LEN_W-1:0] r_len;
    logic [OFF_W-1:0] r_pay;
    logic [AW-1:0]    r_pos;
    logic [AW-1:0]    r_sz;
    logic             r_split;
    logic             r_out_ok;
    logic [OFF_W-1:0] r_out_off;

    logic [EW-1:0]    w_rdata;
    logic [AW-1:0]    w_rd_size;
    logic             w_rd_free;
    logic             w_we;
    logic             w_re;
    logic [AW-1:0]    w_addr;
    logic [EW-1:0]    w_wdata;

    logic [CW-1:0]    c_pos, c_len, c_rsz, c_sz, c_hdr, c_heap;
    logic [CW-1:0]    c_npos, c_blk_pay, c_split_addr, c_split_size;
    logic [CW-1:0]    c_next_addr, c_merge_size;

    assign w_rd_size = w_rdata[AW-1:0];
    assign w_rd_free = w_rdata[AW];

    assign c_pos  = CW'(r_pos);
    assign c_len  = CW'(r_len);
    assign c_rsz  = CW'(w_rd_size);
    assign c_sz   = CW'(r_sz);
    assign c_hdr  = CW'(HEADER_BYTES);
    assign c_heap = CW'(HEAP_BYTES);

    assign c_npos       = c_pos + c_rsz + c_hdr;
    assign c_blk_pay    = c_pos + c_hdr;
    assign c_split_addr = c_pos + c_hdr + c_len;
    assign c_split_size = c_sz - c_len - c_hdr;
    assign c_next_addr  = c_pos + c_hdr + c_sz;
    assign c_merge_size = c_sz + c_hdr + c_rsz;

    always_comb begin
        o_stat.is_free_op = (r_op == OP_FREE);
        o_stat.rd_free    = w_rd_free;
        o_stat.fits       = w_rd_free && (c_rsz >= c_len);
        o_stat.split_ok   = c_rsz >= (c_len + c_hdr + CW'(1));
        o_stat.next_end   = (c_npos + c_hdr) > c_heap;
        o_stat.match      = c_blk_pay == CW'(r_pay);
        o_stat.past       = c_blk_pay > CW'(r_pay);
    end

    always_comb begin
        w_we    = 1'b1;
        w_re    = i_cmd.rd;
        w_addr  = r_pos;
        w_wdata = {1'b0, r_sz};
        unique case (i_cmd.wr)
            WR_NONE: begin
                w_we = 1'b0;
                if (i_cmd.rd_sel == RD_NEXT) begin
                    w_addr = c_next_addr[AW-1:0];
                end
            end
            WR_INIT: begin
                w_addr  = '0;
                w_wdata = {1'b1, AW'(HEAP_BYTES - HEADER_BYTES)};
            end
            WR_SPLIT: begin
                w_addr  = c_split_addr[AW-1:0];
                w_wdata = {1'b1, c_split_size[AW-1:0]};
            end
            WR_MARK: begin
                w_wdata = {1'b0, r_split ? c_len[AW-1:0] : r_sz};
            end
            WR_FREE: begin
                w_wdata = {1'b1, r_sz};
            end
            WR_MERGE: begin
                w_wdata = {1'b1, c_merge_size[AW-1:0]};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    ilff_ram #(
        .WIDTH (EW),
        .DEPTH (HEAP_BYTES)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op  <= i_s_tdata[0];
            r_len <= i_s_tdata[LEN_W:1];
            r_pay <= i_s_tdata[LEN_W+OFF_W:LEN_W+1];
            r_pos <= '0;
        end else if (i_cmd.advance) begin
            r_pos <= c_npos[AW-1:0];
        end
        if (i_cmd.latch) begin
            r_sz    <= w_rd_size;
            r_split <= o_stat.split_ok;
        end
        if (i_cmd.out_load) begin
            r_out_ok  <= i_cmd.out_ok;
            r_out_off <= (i_cmd.out_ok && r_op == OP_ALLOC) ? c_blk_pay[OFF_W-1:0] : '0;
        end
    end

    assign o_m_tdata = {{(M_DATA_W - OFF_W - 1){1'b0}}, r_out_off, r_out_ok};

endmodule

// ===== hw/rtl/implicit_list_first_fit_allocator_unit.sv =====
// walk: a ram read, then an evaluate, per block header; a granted allocate that splits then
// writes the split header and marks the block, a free that checks the following block reads
// and writes it, other grants write one header; o_m_tvalid rises once the output is free
// throughput: one item at a time, the next is taken the cycle after the result is registered
// reset: synchronous active low; the cycle after reset writes header 0 (one free block
// spanning the heap) and the input is not ready during it; other headers are unset
module implicit_list_first_fit_allocator_unit #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [ilff_pkg::S_DATA_W-1:0] i_s_tdata,  // op, request_length, payload_offset_in
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [ilff_pkg::M_DATA_W-1:0] o_m_tdata   // success, payload_offset_out
);

    import ilff_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    ilff_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (w_cmd)
    );

    ilff_dp #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk     (i_clk),
        .i_s_tdata (i_s_tdata),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .o_m_tdata (o_m_tdata)
    );

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while an item is in flight");

    a_fail_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[OFF_W:1] == '0))
        else $error("failed item carries a nonzero offset");

    a_init_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (!o_s_tready && !o_m_tvalid))
        else $error("ready before header 0 is written");
`endif

endmodule

// ===== tb/sv/ilff_alloc_checker.sv =====
`timescale 1ns / 1ps
// result checker for the implicit list first-fit allocator: keeps its own header list,
// predicts every accepted request and compares each result item; depends on ilff_pkg

module ilff_alloc_checker #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [ilff_pkg::S_DATA_W-1:0] i_s_tdata,   // op, request_length, payload_offset_in
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [ilff_pkg::M_DATA_W-1:0] i_m_tdata,   // success, payload_offset_out
    output int                            o_fail_count,
    output int                            o_outstanding
);

    import ilff_pkg::*;

    typedef struct packed {
        logic             is_free;
        logic [LEN_W-1:0] size;
    } t_header;

    typedef struct packed {
        logic             success;
        logic [OFF_W-1:0] offset;
    } t_grant;

    t_header heap_hdr [HEAP_BYTES];
    t_grant  expected_grants [$];
    int      fails = 0;
    t_grant  want;
    t_grant  got;
    logic    req_op;

    function automatic t_grant alloc_first_fit(input logic [LEN_W-1:0] len);
        t_grant g;
        int     pos;
        int     sz;
        int     nxt;
        bit     done;
        g    = '0;
        pos  = 0;
        done = 1'b0;
        while (!done && pos + HEADER_BYTES <= HEAP_BYTES) begin
            sz = int'(heap_hdr[pos].size);
            if (heap_hdr[pos].is_free && sz >= int'(len)) begin
                // split only when the remainder holds a header and a payload byte
                if (sz - int'(len) >= HEADER_BYTES + 1) begin
                    nxt = pos + HEADER_BYTES + int'(len);
                    heap_hdr[nxt].is_free = 1'b1;
                    heap_hdr[nxt].size    = LEN_W'(sz - int'(len) - HEADER_BYTES);
                    heap_hdr[pos].size    = len;
                end
                heap_hdr[pos].is_free = 1'b0;
                g.success = 1'b1;
                g.offset  = OFF_W'(pos + HEADER_BYTES);
                done      = 1'b1;
            end else begin
                pos += sz + HEADER_BYTES;
            end
        end
        return g;
    endfunction

    function automatic t_grant release_block(input logic [OFF_W-1:0] payload);
        t_grant g;
        int     pos;
        int     sz;
        int     nxt;
        bit     done;
        g    = '0;
        pos  = 0;
        done = 1'b0;
        while (!done && pos + HEADER_BYTES <= HEAP_BYTES) begin
            sz = int'(heap_hdr[pos].size);
            if (pos + HEADER_BYTES == int'(payload)) begin
                done = 1'b1;
                if (!heap_hdr[pos].is_free) begin
                    heap_hdr[pos].is_free = 1'b1;
                    nxt = pos + HEADER_BYTES + sz;
                    // merge with the following block only
                    if (nxt + HEADER_BYTES <= HEAP_BYTES && heap_hdr[nxt].is_free) begin
                        heap_hdr[pos].size = LEN_W'(sz + HEADER_BYTES
                                                    + int'(heap_hdr[nxt].size));
                    end
                    g.success = 1'b1;
                end
            end else if (pos + HEADER_BYTES > int'(payload)) begin
                done = 1'b1;
            end else begin
                pos += sz + HEADER_BYTES;
            end
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HEAP_BYTES; k++) begin
                heap_hdr[k] = '0;
            end
            heap_hdr[0].is_free = 1'b1;
            heap_hdr[0].size    = LEN_W'(HEAP_BYTES - HEADER_BYTES);
            expected_grants.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                req_op = i_s_tdata[0];
                if (req_op == OP_ALLOC) begin
                    want = alloc_first_fit(i_s_tdata[LEN_W:1]);
                end else begin
                    want = release_block(i_s_tdata[LEN_W+OFF_W:LEN_W+1]);
                end
                expected_grants.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.success = i_m_tdata[0];
                got.offset  = i_m_tdata[OFF_W:1];
                if (expected_grants.size() == 0) begin
                    $error("result item with no request pending: success %0d offset %0d",
                           got.success, got.offset);
                    fails++;
                end else begin
                    want = expected_grants.pop_front();
                    if (got.success !== want.success) begin
                        $error("success mismatch: expected %0d, actual %0d",
                               want.success, got.success);
                        fails++;
                    end
                    if (got.offset !== want.offset) begin
                        $error("payload_offset_out mismatch: expected %0d, actual %0d",
                               want.offset, got.offset);
                        fails++;
                    end
                end
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= expected_grants.size();
    end

endmodule

// ===== tb/sv/tb_implicit_list_first_fit_allocator_unit.sv =====
`timescale 1ns / 1ps
// top of the allocator testbench: clock, reset, request and result stimulus, verdict
// depends on ilff_pkg, implicit_list_first_fit_allocator_unit and ilff_alloc_checker

module tb_implicit_list_first_fit_allocator_unit;
    import ilff_pkg::*;

    localparam int HEAP_BYTES   = 4096;
    localparam int HEADER_BYTES = 16;
    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 600;
    localparam int CYCLE_LIMIT  = 2_000_000;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                s_tvalid   = 1'b0;
    logic [S_DATA_W-1:0] s_tdata    = '0;
    logic                o_s_tready;
    logic                o_m_tvalid;
    logic                m_tready   = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;

    int               fail_count;
    int               outstanding;
    int               cycles = 0;
    logic [OFF_W-1:0] live_offsets [$];
    bit               tx_burst = 1'b0;
    bit               rx_burst = 1'b0;
    int unsigned      rx_wait  = 0;

    implicit_list_first_fit_allocator_unit #(
        .HEAP_BYTES  (HEAP_BYTES),
        .HEADER_BYTES(HEADER_BYTES)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (o_m_tdata)
    );

    ilff_alloc_checker #(
        .HEAP_BYTES  (HEAP_BYTES),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stall per item, with stretches of no stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else if (m_tready && o_m_tvalid) begin
            if ($urandom_range(0, 31) == 0) begin
                rx_burst = !rx_burst;
            end
            rx_wait = rx_burst ? 0 : $urandom_range(0, 15);
            m_tready <= (rx_wait == 0);
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_tready <= (rx_wait == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // granted payloads, for well-formed frees
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready && o_m_tdata[0] && o_m_tdata[OFF_W:1] != '0) begin
            live_offsets.push_back(o_m_tdata[OFF_W:1]);
        end
    end

    function automatic int unsigned draw_gap();
        if ($urandom_range(0, 31) == 0) begin
            tx_burst = !tx_burst;
        end
        return tx_burst ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic send_item(input logic op, input logic [LEN_W-1:0] len,
                             input logic [OFF_W-1:0] off);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({off, len, op});
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    function automatic logic [LEN_W-1:0] draw_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return LEN_W'($urandom_range(0, 160));
        end else if (r < 95) begin
            return LEN_W'($urandom_range(0, 1024));
        end
        return LEN_W'($urandom_range(0, 4095));
    endfunction

    initial begin
        int unsigned r;
        int unsigned idx;
        logic [OFF_W-1:0] off;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // whole heap without split, then no fit
        send_item(OP_ALLOC, 12'd4080, 12'hFFF);
        send_item(OP_ALLOC, 12'd0, 12'd0);
        send_item(OP_FREE, 12'hFFF, 12'd16);
        // free of a free block and of unknown offsets
        send_item(OP_FREE, 12'd0, 12'd16);
        send_item(OP_FREE, 12'd0, 12'd5);
        send_item(OP_FREE, 12'd0, 12'd4095);
        send_item(OP_FREE, 12'd0, 12'd0);
        // length beyond any free block
        send_item(OP_ALLOC, 12'd4095, 12'd0);
        // zero length, then a grant whose remainder is too small to split
        send_item(OP_ALLOC, 12'd0, 12'd0);
        send_item(OP_ALLOC, 12'd4050, 12'd0);
        send_item(OP_FREE, 12'd0, 12'd32);
        send_item(OP_FREE, 12'd0, 12'd16);
        send_item(OP_ALLOC, 12'd100, 12'd0);
        send_item(OP_ALLOC, 12'd200, 12'd0);
        send_item(OP_FREE, 12'd0, 12'd16);
        send_item(OP_ALLOC, 12'd50, 12'd0);
        send_item(OP_FREE, 12'd0, 12'd132);
        send_item(OP_FREE, 12'd0, 12'd16);
        send_item(OP_FREE, 12'd0, 12'd132);
        send_item(OP_ALLOC, 12'd4080, 12'd0);
        wait_drained();
        live_offsets.delete();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) begin
                wait_drained();
            end
            r = $urandom_range(0, 99);
            if (r >= 50 && r < 90 && live_offsets.size() > 0) begin
                idx = $urandom_range(0, live_offsets.size() - 1);
                off = live_offsets[idx];
                live_offsets.delete(idx);
                send_item(OP_FREE, LEN_W'($urandom), off);
            end else if (r >= 90) begin
                send_item(OP_FREE, LEN_W'($urandom), OFF_W'($urandom));
            end else begin
                send_item(OP_ALLOC, draw_length(), OFF_W'($urandom));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ilff_pkg.sv
hw/rtl/ilff_ram.sv
hw/rtl/ilff_ctrl.sv
hw/rtl/ilff_dp.sv
hw/rtl/implicit_list_first_fit_allocator_unit.sv
tb/sv/ilff_alloc_checker.sv
tb/sv/tb_implicit_list_first_fit_allocator_unit.sv
